[hw/rtl/fuzzy_rate_budget_controller_macros.svh]
// Assertion shorthands used by the controller RTL, which checks itself.
`ifndef FUZZY_RATE_BUDGET_CONTROLLER_MACROS_SVH
`define FUZZY_RATE_BUDGET_CONTROLLER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define FRBC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define FRBC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/frbc_pkg.sv]
package frbc_pkg;

  localparam int RULE_COUNT = 3;

  // Target register, unsigned Q7.8.
  localparam int TFR_W = 15;
  localparam logic [TFR_W-1:0] TFR_MIN   = 15'd2560;
  localparam logic [TFR_W-1:0] TFR_MAX   = 15'd20480;
  localparam logic [TFR_W-1:0] TFR_RESET = 15'd5120;

  // Triangle corner positions, signed, in units of 1/512 fps.
  localparam int POS_W = 19;
  localparam logic signed [POS_W-1:0] LOW_LO    = -19'sd10240;
  localparam logic signed [POS_W-1:0] LOW_CE_OF = -19'sd5632;
  localparam logic signed [POS_W-1:0] LOW_UP_OF = -19'sd1024;
  localparam logic signed [POS_W-1:0] OK_HALF   = 19'sd10240;
  localparam logic signed [POS_W-1:0] HIGH_LO_OF = 19'sd1024;
  localparam logic signed [POS_W-1:0] HIGH_CE_OF = 19'sd38912;
  localparam logic signed [POS_W-1:0] HIGH_UP    = 19'sd76800;

  // Membership: distance and half-width, quotient in Q1.16.
  localparam int DIST_W = 16;
  localparam int MEMB_W = 17;

  // Clipped area and centroid correction.
  localparam int SQ_W   = 34;
  localparam int CUBE_W = 49;
  localparam int W_W    = 28;
  localparam int Q0_W   = 22;
  // floor(2^34 / 125): reciprocal for the exact divide by 125.
  localparam logic [W_W-1:0] RECIP_125 = 28'd137438953;
  localparam int RECIP_SH = 34;
  localparam logic [W_W:0] DIV_125 = 29'd125;

  // Weighted centroid.
  localparam int NUM_W = 37;
  localparam int DEN_W = 36;
  localparam int OUT_W = 16;
  localparam int FRAC_SH = 14;

  // Sideband bits carried through the final divider.
  localparam int SB_VALID = 0;
  localparam int SB_NEG   = 1;
  localparam int SB_ZERO  = 2;
  localparam int SB_W     = 3;

endpackage

[hw/rtl/fuzzy_rate_budget_controller.sv]
// Channel  Dir  Signals                          Content
// s_       in   s_tvalid s_tready s_tdata[15:0]  measured frame rate
// m_       out  m_tvalid m_tready m_tdata[15:0]  budget change
//                         m_tuser                no-activation flag
// cfg_     in   cfg_we cfg_wdata[14:0]           target frame rate
//
// The datapath is a 41-stage pipeline: one input capture stage, 17 stages of
// the membership divider, five stages of area and centroid arithmetic, one
// capture and 16 stages of the final divider, and the output register.
// One transfer is accepted per cycle while the output is not stalled.
// A stall on the output freezes every stage at once, so nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and loads the target with 20 fps.
module fuzzy_rate_budget_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] frame_rate
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] budget_change
  output logic        m_tuser,   // [0] no_activation
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);

  localparam int NR  = frbc_pkg::RULE_COUNT;
  localparam int PW  = frbc_pkg::POS_W;
  localparam int DSW = frbc_pkg::DIST_W;
  localparam int MW  = frbc_pkg::MEMB_W;

  // The whole pipeline moves together whenever the output slot can take a value.
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Target register, saturated on write.
  logic [frbc_pkg::TFR_W-1:0] target;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= frbc_pkg::TFR_RESET;
    end else if (cfg_we) begin
      if (cfg_wdata < frbc_pkg::TFR_MIN) begin
        target <= frbc_pkg::TFR_MIN;
      end else if (cfg_wdata > frbc_pkg::TFR_MAX) begin
        target <= frbc_pkg::TFR_MAX;
      end else begin
        target <= cfg_wdata;
      end
    end
  end

  // Input stage: place the three triangles around the target and pick the side
  // of each one that the sample falls on. The membership is then the distance
  // from the outer corner over the half-width of that side.
  logic signed [PW-1:0] x_pos;
  logic signed [PW-1:0] t1;
  logic signed [PW-1:0] t2;
  logic signed [PW-1:0] lo [NR];
  logic signed [PW-1:0] ce [NR];
  logic signed [PW-1:0] up [NR];
  logic [NR-1:0][DSW-1:0] span;
  logic [NR-1:0][DSW-1:0] half;
  logic [NR-1:0][DSW-1:0] memb_rem;
  logic [NR-1:0][MW-1:0]  memb_bits;
  logic [NR-1:0][MW-1:0]  memb;
  logic                   memb_valid;

  assign x_pos = $signed({2'b00, s_tdata, 1'b0});
  assign t1    = $signed({4'b0000, target});
  assign t2    = $signed({3'b000, target, 1'b0});

  assign lo[0] = frbc_pkg::LOW_LO;
  assign ce[0] = t1 + frbc_pkg::LOW_CE_OF;
  assign up[0] = t2 + frbc_pkg::LOW_UP_OF;
  assign lo[1] = t2 - frbc_pkg::OK_HALF;
  assign ce[1] = t2;
  assign up[1] = t2 + frbc_pkg::OK_HALF;
  assign lo[2] = t2 + frbc_pkg::HIGH_LO_OF;
  assign ce[2] = t1 + frbc_pkg::HIGH_CE_OF;
  assign up[2] = frbc_pkg::HIGH_UP;

  for (genvar r = 0; r < NR; r++) begin : g_side
    logic signed [PW-1:0] d_fall;
    logic signed [PW-1:0] w_fall;
    logic signed [PW-1:0] d_rise;
    logic signed [PW-1:0] w_rise;
    assign d_fall = up[r] - x_pos;
    assign w_fall = up[r] - ce[r];
    assign d_rise = x_pos - lo[r];
    assign w_rise = ce[r] - lo[r];

    always_comb begin
      if (x_pos > ce[r] && x_pos < up[r]) begin
        span[r] = d_fall[DSW-1:0];
        half[r] = w_fall[DSW-1:0];
      end else if (x_pos <= ce[r] && x_pos > lo[r]) begin
        span[r] = d_rise[DSW-1:0];
        half[r] = w_rise[DSW-1:0];
      end else begin
        // Outside the triangle: zero over one gives membership zero.
        span[r] = '0;
        half[r] = DSW'(1);
      end
    end

    // Dividend is span << 16; its upper part never reaches the half-width.
    assign memb_rem[r]  = {1'b0, span[r][DSW-1:1]};
    assign memb_bits[r] = {span[r][0], {(MW-1){1'b0}}};
  end

  frbc_udiv #(
    .LANES(NR),
    .DW   (DSW),
    .QW   (MW),
    .SW   (1)
  ) u_memb_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_side (s_tvalid),
    .in_rem  (memb_rem),
    .in_bits (memb_bits),
    .in_dvs  (half),
    .out_quo (memb),
    .out_side(memb_valid)
  );

  // Stage P1: square of the membership.
  logic [NR-1:0][MW-1:0]                 p1_c;
  logic [NR-1:0][frbc_pkg::SQ_W-1:0]     p1_sq;
  logic                                  p1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= memb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < NR; r++) begin
        p1_c[r]  <= memb[r];
        p1_sq[r] <= frbc_pkg::SQ_W'(memb[r] * memb[r]);
      end
    end
  end

  // Stage P2: clipped area (c << 17) - c^2, and the cube scaled down by 2^21.
  logic [NR-1:0][frbc_pkg::SQ_W-1:0]   p2_area;
  logic [NR-1:0][frbc_pkg::W_W-1:0]    p2_w;
  logic [NR-1:0][frbc_pkg::CUBE_W-1:0] cube;
  logic                                p2_valid;

  for (genvar r = 0; r < NR; r++) begin : g_cube
    assign cube[r] = frbc_pkg::CUBE_W'(p1_sq[r] * p1_c[r]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (adv) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < NR; r++) begin
        p2_area[r] <= {p1_c[r], {(frbc_pkg::SQ_W-MW){1'b0}}} - p1_sq[r];
        p2_w[r]    <= cube[r][frbc_pkg::CUBE_W-1 -: frbc_pkg::W_W];
      end
    end
  end

  // Stage P3: estimate of w / 125 by the reciprocal; it is low by at most one.
  logic [NR-1:0][frbc_pkg::SQ_W-1:0] p3_area;
  logic [NR-1:0][frbc_pkg::W_W-1:0]  p3_w;
  logic [NR-1:0][frbc_pkg::Q0_W-1:0] p3_q0;
  logic [NR-1:0][2*frbc_pkg::W_W-1:0] recip_prod;
  logic                              p3_valid;

  for (genvar r = 0; r < NR; r++) begin : g_recip
    assign recip_prod[r] = p2_w[r] * frbc_pkg::RECIP_125;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (adv) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < NR; r++) begin
        p3_area[r] <= p2_area[r];
        p3_w[r]    <= p2_w[r];
        p3_q0[r]   <= recip_prod[r][frbc_pkg::RECIP_SH +: frbc_pkg::Q0_W];
      end
    end
  end

  // Stage P4: correct the estimate with one compare against the remainder.
  logic [NR-1:0][frbc_pkg::SQ_W-1:0] p4_area;
  logic [NR-1:0][frbc_pkg::Q0_W-1:0] p4_bias;
  logic [NR-1:0][frbc_pkg::W_W:0]    resid;
  logic                              p4_valid;

  for (genvar r = 0; r < NR; r++) begin : g_fix
    assign resid[r] = {1'b0, p3_w[r]} - (frbc_pkg::W_W+1)'(p3_q0[r] * frbc_pkg::DIV_125);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else if (adv) begin
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < NR; r++) begin
        p4_area[r] <= p3_area[r];
        p4_bias[r] <= p3_q0[r] + frbc_pkg::Q0_W'(resid[r] >= frbc_pkg::DIV_125);
      end
    end
  end

  // Stage P5: numerator and denominator of the centroid. The rules' output
  // centres are -1, 0 and +1, so the numerator is a signed sum of areas less the centroid corrections.
  logic signed [frbc_pkg::NUM_W-1:0] p5_num;
  logic [frbc_pkg::DEN_W-1:0]        p5_den;
  logic                              p5_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_valid <= 1'b0;
    end else if (adv) begin
      p5_valid <= p4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_num <= $signed(frbc_pkg::NUM_W'(p4_area[2])) - $signed(frbc_pkg::NUM_W'(p4_area[0]))
              - $signed(frbc_pkg::NUM_W'(p4_bias[0])) - $signed(frbc_pkg::NUM_W'(p4_bias[1]))
              - $signed(frbc_pkg::NUM_W'(p4_bias[2]));
      p5_den <= frbc_pkg::DEN_W'(p4_area[0]) + frbc_pkg::DEN_W'(p4_area[1])
              + frbc_pkg::DEN_W'(p4_area[2]);
    end
  end

  // Rounded quotient of the magnitude: (|num| * 2^14 + den / 2) / den.
  localparam int NQ_W = frbc_pkg::DEN_W + frbc_pkg::FRAC_SH;
  logic                              num_neg;
  logic [frbc_pkg::DEN_W-1:0]        num_mag;
  logic [frbc_pkg::NUM_W-1:0]        num_abs;
  logic [NQ_W-1:0]                   quot_dend;
  logic [0:0][frbc_pkg::DEN_W-1:0]   fin_rem;
  logic [0:0][frbc_pkg::OUT_W-1:0]   fin_bits;
  logic [0:0][frbc_pkg::DEN_W-1:0]   fin_dvs;
  logic [0:0][frbc_pkg::OUT_W-1:0]   fin_quo;
  logic [frbc_pkg::SB_W-1:0]         fin_side_in;
  logic [frbc_pkg::SB_W-1:0]         fin_side;

  assign num_neg   = p5_num[frbc_pkg::NUM_W-1];
  assign num_abs   = num_neg ? frbc_pkg::NUM_W'(-p5_num) : frbc_pkg::NUM_W'(p5_num);
  assign num_mag   = num_abs[frbc_pkg::DEN_W-1:0];
  assign quot_dend = {num_mag, {frbc_pkg::FRAC_SH{1'b0}}} + NQ_W'(p5_den >> 1);
  assign fin_rem[0]  = frbc_pkg::DEN_W'(quot_dend[NQ_W-1:frbc_pkg::OUT_W]);
  assign fin_bits[0] = quot_dend[frbc_pkg::OUT_W-1:0];
  assign fin_dvs[0]  = p5_den;

  always_comb begin
    fin_side_in                    = '0;
    fin_side_in[frbc_pkg::SB_VALID] = p5_valid;
    fin_side_in[frbc_pkg::SB_NEG]   = num_neg;
    fin_side_in[frbc_pkg::SB_ZERO]  = (p5_den == '0);
  end

  frbc_udiv #(
    .LANES(1),
    .DW   (frbc_pkg::DEN_W),
    .QW   (frbc_pkg::OUT_W),
    .SW   (frbc_pkg::SB_W)
  ) u_cent_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_side (fin_side_in),
    .in_rem  (fin_rem),
    .in_bits (fin_bits),
    .in_dvs  (fin_dvs),
    .out_quo (fin_quo),
    .out_side(fin_side)
  );

  // Output register: apply the sign, or force zero when no rule fired.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= fin_side[frbc_pkg::SB_VALID];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser <= fin_side[frbc_pkg::SB_ZERO];
      if (fin_side[frbc_pkg::SB_ZERO]) begin
        m_tdata <= '0;
      end else if (fin_side[frbc_pkg::SB_NEG]) begin
        m_tdata <= -fin_quo[0];
      end else begin
        m_tdata <= fin_quo[0];
      end
    end
  end

`include "fuzzy_rate_budget_controller_macros.svh"

  // A result flagged as having no active rule carries a zero change.
  `FRBC_ASSERT_IMPLY(a_zero_when_idle, clk, rst, m_tvalid && m_tuser, m_tdata == '0, "flag set with nonzero change")

  // The change stays within about one and a half units either way.
  `FRBC_ASSERT_IMPLY(a_change_bound, clk, rst, m_tvalid, $signed(m_tdata) >= -16'sd24576 && $signed(m_tdata) <= 16'sd24576, "change out of range")

  // The target never leaves its saturation window.
  `FRBC_ASSERT_ALWAYS(a_target_window, clk, rst, target >= frbc_pkg::TFR_MIN && target <= frbc_pkg::TFR_MAX, "target outside window")

endmodule

[hw/rtl/frbc_udiv.sv]
// Pipelined restoring divider: a capture stage, then one quotient bit per register stage;
// several lanes share one sideband word that travels with them.
module frbc_udiv #(
  parameter int LANES = 1,
  parameter int DW    = 16,
  parameter int QW    = 16,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [SW-1:0]              in_side,
  input  logic [LANES-1:0][DW-1:0]   in_rem,
  input  logic [LANES-1:0][QW-1:0]   in_bits,
  input  logic [LANES-1:0][DW-1:0]   in_dvs,
  output logic [LANES-1:0][QW-1:0]   out_quo,
  output logic [SW-1:0]              out_side
);

  logic [LANES-1:0][DW-1:0] rem  [QW+1];
  logic [LANES-1:0][QW-1:0] bits [QW+1];
  logic [LANES-1:0][DW-1:0] dvs  [QW+1];
  logic [LANES-1:0][QW-1:0] quo  [QW+1];
  logic [SW-1:0]            side [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      side[0] <= '0;
    end else if (en) begin
      side[0] <= in_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= in_rem;
      bits[0] <= in_bits;
      dvs[0]  <= in_dvs;
      quo[0]  <= '0;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [LANES-1:0][DW-1:0] rem_next;
    logic [LANES-1:0][QW-1:0] quo_next;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW:0] trial;
      logic        ge;
      logic [DW:0] diff;
      assign trial = {rem[s-1][l], bits[s-1][l][QW-s]};
      assign ge    = trial >= {1'b0, dvs[s-1][l]};
      assign diff  = trial - {1'b0, dvs[s-1][l]};
      assign rem_next[l] = ge ? diff[DW-1:0] : trial[DW-1:0];
      assign quo_next[l] = {quo[s-1][l][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side[s] <= '0;
      end else if (en) begin
        side[s] <= side[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= rem_next;
        bits[s] <= bits[s-1];
        dvs[s]  <= dvs[s-1];
        quo[s]  <= quo_next;
      end
    end
  end

  assign out_quo  = quo[QW];
  assign out_side = side[QW];

endmodule

[tb/fuzzy_rate_budget_controller_tb.sv]
module fuzzy_rate_budget_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Output of the controller for one measured rate: budget change and flag.
  typedef struct packed {
    logic [15:0] budget;
    logic        idle_flag;
  } budget_result_t;

  localparam int PIPE_LATENCY = 41;
  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_wdata = '0;

  // The predictor keeps its own copy of the target register.
  logic [frbc_pkg::TFR_W-1:0] target_q88;
  budget_result_t   pending_budgets[$];

  int  mismatches = 0;
  int  checked = 0;
  int  sent = 0;
  int  quiet_cycles = 0;
  bit  timed_out = 1'b0;
  bit  no_idle_sink = 1'b0;
  bit  no_idle_source = 1'b0;
  bit  sink_hold = 1'b0;
  int  flagged_seen = 0;
  int  settings_seen = 0;

  fuzzy_rate_budget_controller uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Triangle membership in Q1.16, truncated; zero outside the open support.
  function automatic longint unsigned membership(longint x, longint lo, longint ce,
                                                 longint up);
    if (x > ce && x < up) begin
      if (up <= ce) return 0;
      return (longint'(up - x) << 16) / longint'(up - ce);
    end
    if (x <= ce && x > lo) begin
      if (ce <= lo) return 0;
      return (longint'(x - lo) << 16) / longint'(ce - lo);
    end
    return 0;
  endfunction

  // Weighted centroid over the three clipped output triangles.
  function automatic budget_result_t predict_budget(logic [15:0] rate);
    budget_result_t r;
    longint x, t, num, lo[3], ce[3], up[3];
    longint unsigned c, area, bias, den, mag, q;
    x = longint'(rate) * 2;
    t = longint'(target_q88);
    lo[0] = -10240;          ce[0] = t - 5632;  up[0] = 2 * t - 1024;
    lo[1] = 2 * t - 10240;   ce[1] = 2 * t;     up[1] = 2 * t + 10240;
    lo[2] = 2 * t + 1024;    ce[2] = t + 38912; up[2] = 76800;
    num = 0;
    den = 0;
    for (int i = 0; i < frbc_pkg::RULE_COUNT; i++) begin
      c = membership(x, lo[i], ce[i], up[i]);
      area = (c << 17) - c * c;
      bias = ((c * c * c) >> 15) / 64'd8000;
      // Rule centres are -1, 0 and +1 in rule order.
      num += longint'(i - 1) * longint'(area) - longint'(bias);
      den += area;
    end
    if (den == 0) begin
      r.budget = '0;
      r.idle_flag = 1'b1;
    end else begin
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = (mag * 16384 + den / 2) / den;
      r.budget = (num < 0) ? 16'(-longint'(q)) : 16'(q);
      r.idle_flag = 1'b0;
    end
    return r;
  endfunction

  // Sends one rate sample and records the expected budget when it is accepted.
  // The valid stays high after the transfer until the next idle gap or drain.
  task automatic send_rate(logic [15:0] rate);
    while (!no_idle_source && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rate;
    do @(posedge clk); while (!s_tready);
    pending_budgets.push_back(predict_budget(rate));
    sent++;
  endtask

  // Waits until every expected result is back and the pipeline has drained.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_budgets.size() != 0 && !timed_out) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  // The register is written only while the pipeline is empty.
  task automatic write_target(logic [14:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    target_q88 = (value < frbc_pkg::TFR_MIN) ? frbc_pkg::TFR_MIN :
                 (value > frbc_pkg::TFR_MAX) ? frbc_pkg::TFR_MAX : value;
    settings_seen++;
  endtask

  // Rates around every triangle corner that a rate can reach for the present target.
  task automatic test_corners();
    int t;
    int pts[15];
    t = int'(target_q88);
    pts = '{0, 1, t / 2 - 2816, t - 512, t - 513, t - 5120, t, t + 1, t + 5120,
            t + 512, t / 2 + 19456, 38399, 38400, 38401, 65535};
    foreach (pts[i]) begin
      if (pts[i] >= 0 && pts[i] <= 65535) send_rate(16'(pts[i]));
    end
  endtask

  // Reset value, then both saturation ends and out-of-range writes.
  task automatic test_target_extremes();
    test_corners();
    write_target(15'd0);
    test_corners();
    write_target(15'h7FFF);
    test_corners();
    write_target(frbc_pkg::TFR_MIN);
    send_rate(16'hAAAA);
    send_rate(16'h5555);
    write_target(frbc_pkg::TFR_MAX);
    send_rate(16'hFFFF);
  endtask

  // Random rates, mostly in the band where the rules fire.
  task automatic test_random_rates(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) send_rate(16'($urandom_range(38500)));
      else send_rate(16'($urandom));
    end
  endtask

  // Sweeps several targets with random traffic, including a no-idle stretch.
  task automatic test_random_targets();
    for (int k = 0; k < 6; k++) begin
      write_target(15'($urandom));
      no_idle_sink   = (k == 2);
      no_idle_source = (k == 2);
      test_random_rates(230);
    end
    no_idle_sink = 1'b0;
    no_idle_source = 1'b0;
  endtask

  // The sink holds off long enough that the pipeline fills and stalls its input.
  task automatic test_backpressure();
    drain();
    sink_hold = 1'b1;
    no_idle_source = 1'b1;
    fork
      test_random_rates(80);
      begin
        repeat (150) @(posedge clk);
        sink_hold = 1'b0;
      end
    join
    no_idle_source = 1'b0;
  endtask

  // Sink readiness: random idling unless a hold or a no-idle stretch is on.
  always @(posedge clk) begin
    if (sink_hold) m_tready <= 1'b0;
    else if (no_idle_sink) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(99) >= 27);
  end

  // Compares each transfer on the output with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      budget_result_t want;
      if (pending_budgets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: budget=%h flag=%b", m_tdata, m_tuser);
      end else begin
        want = pending_budgets.pop_front();
        checked++;
        if (want.idle_flag) flagged_seen++;
        if (m_tdata !== want.budget || m_tuser !== want.idle_flag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: budget exp %h got %h, flag exp %b got %b",
                     want.budget, m_tdata, want.idle_flag, m_tuser);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("** fuzzy_rate_budget_controller: FAILED **");
      $finish;
    end
  end

  initial begin
    target_q88 = frbc_pkg::TFR_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_target_extremes();
    test_random_targets();
    test_backpressure();
    write_target(frbc_pkg::TFR_RESET);
    test_random_rates(100);
    drain();
    $display("Sent %0d rates and checked %0d results (%0d with no rule firing)",
             sent, checked, flagged_seen);
    $display("over %0d target settings, with idle gaps, a no-idle run and a long hold.",
             settings_seen);
    if (mismatches == 0 && pending_budgets.size() == 0) begin
      $display("** fuzzy_rate_budget_controller: PASSED **");
    end else begin
      $display("** fuzzy_rate_budget_controller: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/frbc_pkg.sv
hw/rtl/frbc_udiv.sv
hw/rtl/fuzzy_rate_budget_controller.sv
tb/fuzzy_rate_budget_controller_tb.sv
